FILE: sv/swcc_pkg.sv
// swcc_pkg: shared constants and codes for the set-associative write-back cache directory
// depends on: nothing
package swcc_pkg;

  // default geometry of the directory
  localparam int DEF_WAYS         = 4;
  localparam int DEF_SETS         = 64;
  localparam int DEF_LINE_BYTES   = 32;
  localparam int DEF_ADDRESS_BITS = 32;

  // fixed widths of the transfer fields
  localparam int OPCODE_W   = 2;
  localparam int ADDR_IN_W  = 32;
  localparam int WAY_OUT_W  = 2;
  localparam int LINE_OUT_W = 27;

  // request codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INVAL  = 2'd2,
    OP_IGNORE = 2'd3
  } opcode_t;

endpackage

FILE: sv/swcc_ram.sv
// swcc_ram: generic single-write, single-read ram with registered read data
// depends on: nothing
module swcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/set_assoc_writeback_cache_ctrl_core.sv
// set_assoc_writeback_cache_ctrl_core: tag, valid, dirty and lru age directory of a
// set-associative write-back, write-allocate cache
// depends on: swcc_pkg, swcc_ram
//
// channel | direction | handshake            | fields
// --------+-----------+----------------------+----------------------------------------------
// in      | to core   | in_valid / in_stall  | opcode, address
// out     | from core | out_valid / out_stall| hit, way, fill_request, fill_line_address,
//         |           |                      | writeback_request, writeback_line_address,
//         |           |                      | evicted_clean, first_modify
//
// one request is in flight at a time; on its transfer a request reads the set's row from
// the directory ram, then passes one way per cycle through the single tag and age comparator
// (a hit stops the scan early), and then writes the row back and loads the result register.
// after reset a clearing pass writes every row, one set per cycle; in_stall stays high
// meanwhile. the result register lets a new request in while a result waits, and a finished
// request waits in its write-back cycle while out_stall holds the previous result.
module set_assoc_writeback_cache_ctrl_core
  import swcc_pkg::*;
#(
  parameter int WAYS         = DEF_WAYS,
  parameter int SETS         = DEF_SETS,
  parameter int LINE_BYTES   = DEF_LINE_BYTES,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OPCODE_W-1:0]   opcode,
  input  logic [ADDR_IN_W-1:0]  address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  hit,
  output logic [WAY_OUT_W-1:0]  way,
  output logic                  fill_request,
  output logic [LINE_OUT_W-1:0] fill_line_address,
  output logic                  writeback_request,
  output logic [LINE_OUT_W-1:0] writeback_line_address,
  output logic                  evicted_clean,
  output logic                  first_modify
);

  // address split and row layout
  localparam int OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
  localparam int IDX_BITS = $clog2(SETS + 1) - 1;
  localparam int LINE_W   = ADDRESS_BITS - OFF_BITS;
  localparam int TAG_RAW  = LINE_W - IDX_BITS;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ENTRY_W  = 2 + WAY_W + TAG_W;
  localparam int ROW_W    = WAYS * ENTRY_W;
  localparam logic [SET_W-1:0] SET_MASK = SET_W'((1 << IDX_BITS) - 1);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t            state;
  logic [SET_W-1:0]  clr_set;
  opcode_t           req_op;
  logic [LINE_W-1:0] req_line;
  logic [SET_W-1:0]  req_set;
  logic [TAG_W-1:0]  req_tag;
  logic [SET_W-1:0]  in_set;
  logic              in_xfer;
  logic              update_fire;

  // scan state
  logic [WAY_W-1:0]  scan_idx;
  logic              found;
  logic [WAY_W-1:0]  found_way;
  logic              inv_found;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  victim_way;
  logic [WAY_W-1:0]  victim_age;

  // directory row
  logic [ROW_W-1:0]  row_q;
  logic [ROW_W-1:0]  row_next;
  logic [ROW_W-1:0]  reset_row;
  logic              wr_en;
  logic [SET_W-1:0]  wr_addr;
  logic [ROW_W-1:0]  wr_data;

  logic              ent_valid [WAYS];
  logic              ent_dirty [WAYS];
  logic [WAY_W-1:0]  ent_age   [WAYS];
  logic [TAG_W-1:0]  ent_tag   [WAYS];
  logic              cur_valid;
  logic [WAY_W-1:0]  cur_age;
  logic [TAG_W-1:0]  cur_tag;

  // result of the update cycle
  logic              res_hit;
  logic [WAY_W-1:0]  res_way;
  logic              res_fill;
  logic              res_wb;
  logic [LINE_W-1:0] res_wb_addr;
  logic              res_ev_clean;
  logic              res_first_mod;

  // request decode
  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign in_set   = SET_W'(address[ADDRESS_BITS-1:OFF_BITS]) & SET_MASK;
  assign req_set  = SET_W'(req_line) & SET_MASK;
  assign req_tag  = TAG_W'(req_line >> IDX_BITS);
  assign update_fire = (state == ST_UPDATE) && (!out_valid || !out_stall);

  // directory ram write source
  assign wr_en   = (state == ST_CLEAR) || update_fire;
  assign wr_addr = (state == ST_CLEAR) ? clr_set : req_set;
  assign wr_data = (state == ST_CLEAR) ? reset_row : row_next;

  swcc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_dir_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_xfer),
    .rd_addr (in_set),
    .rd_data (row_q)
  );

  // unpack the row and build the after-reset row
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      ent_valid[i] = row_q[i*ENTRY_W + ENTRY_W - 1];
      ent_dirty[i] = row_q[i*ENTRY_W + ENTRY_W - 2];
      ent_age[i]   = row_q[i*ENTRY_W + TAG_W +: WAY_W];
      ent_tag[i]   = row_q[i*ENTRY_W +: TAG_W];
      reset_row[i*ENTRY_W +: ENTRY_W] = {1'b0, 1'b0, WAY_W'(i), TAG_W'(0)};
    end
  end

  // the way under the shared comparator
  assign cur_valid = ent_valid[scan_idx];
  assign cur_age   = ent_age[scan_idx];
  assign cur_tag   = ent_tag[scan_idx];

  // new row and result for the request
  always_comb begin
    logic             n_valid [WAYS];
    logic             n_dirty [WAYS];
    logic [WAY_W-1:0] n_age   [WAYS];
    logic [TAG_W-1:0] n_tag   [WAYS];
    logic [WAY_W-1:0] sel_way;
    logic [WAY_W-1:0] pivot;
    for (int i = 0; i < WAYS; i++) begin
      n_valid[i] = ent_valid[i];
      n_dirty[i] = ent_dirty[i];
      n_age[i]   = ent_age[i];
      n_tag[i]   = ent_tag[i];
    end
    sel_way       = found ? found_way : (inv_found ? inv_way : victim_way);
    pivot         = ent_age[sel_way];
    res_hit       = 1'b0;
    res_way       = '0;
    res_fill      = 1'b0;
    res_wb        = 1'b0;
    res_wb_addr   = '0;
    res_ev_clean  = 1'b0;
    res_first_mod = 1'b0;
    case (req_op) inside
      OP_READ, OP_WRITE: begin
        for (int i = 0; i < WAYS; i++) begin
          if (WAY_W'(i) == sel_way) begin
            n_valid[i] = 1'b1;
            n_dirty[i] = (found && ent_dirty[i]) || (req_op == OP_WRITE);
            n_age[i]   = '0;
            n_tag[i]   = found ? ent_tag[i] : req_tag;
          end else if (ent_age[i] < pivot) begin
            n_age[i] = ent_age[i] + WAY_W'(1);
          end
        end
        res_hit = found;
        res_way = sel_way;
        if (!found) begin
          res_fill = 1'b1;
          if (!inv_found) begin
            if (ent_dirty[sel_way]) begin
              res_wb      = 1'b1;
              res_wb_addr = (LINE_W'(ent_tag[sel_way]) << IDX_BITS) | LINE_W'(req_set);
            end else begin
              res_ev_clean = 1'b1;
            end
          end
        end
        res_first_mod = (req_op == OP_WRITE) && !(found && ent_dirty[sel_way]);
      end
      OP_INVAL: begin
        if (found) begin
          for (int i = 0; i < WAYS; i++) begin
            if (WAY_W'(i) == found_way) begin
              n_valid[i] = 1'b0;
              n_dirty[i] = 1'b0;
            end
          end
          res_hit     = 1'b1;
          res_way     = found_way;
          res_wb      = ent_dirty[found_way];
          res_wb_addr = ent_dirty[found_way] ? req_line : '0;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < WAYS; i++) begin
      row_next[i*ENTRY_W +: ENTRY_W] = {n_valid[i], n_dirty[i], n_age[i], n_tag[i]};
    end
  end

  // sequencer: clearing pass, request capture, way scan, write-back of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_set <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_set <= clr_set + SET_W'(1);
          if (clr_set == LAST_SET) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if ((cur_valid && cur_tag == req_tag) || scan_idx == LAST_WAY) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (update_fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // request capture and per-way compare results
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_op    <= opcode_t'(opcode);
      req_line  <= address[ADDRESS_BITS-1:OFF_BITS];
      scan_idx  <= '0;
      found     <= 1'b0;
      inv_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (cur_valid && cur_tag == req_tag) begin
        found     <= 1'b1;
        found_way <= scan_idx;
      end else begin
        if (!cur_valid) begin
          inv_found <= 1'b1;
          inv_way   <= scan_idx;
        end
        scan_idx <= scan_idx + WAY_W'(1);
      end
      if (scan_idx == '0 || cur_age > victim_age) begin
        victim_way <= scan_idx;
        victim_age <= cur_age;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (update_fire) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update_fire) begin
      hit                    <= res_hit;
      way                    <= WAY_OUT_W'(res_way);
      fill_request           <= res_fill;
      fill_line_address      <= res_fill ? LINE_OUT_W'(req_line) : '0;
      writeback_request      <= res_wb;
      writeback_line_address <= LINE_OUT_W'(res_wb_addr);
      evicted_clean          <= res_ev_clean;
      first_modify           <= res_first_mod;
    end
  end

endmodule
